FILE: rtl/core/bsle_pkg.sv
// shared types and constants for the bounded sequential list engine
package bsle_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_READ     = 3'd3,
    OP_LOCATE   = 3'd4,
    OP_SWAP     = 3'd5,
    OP_EXTREMES = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CM_HOLD = 3'd0,
    CM_ROT  = 3'd1,
    CM_INS  = 3'd2,
    CM_DEL  = 3'd3,
    CM_SWAP = 3'd4
  } cell_mode_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         second_position;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length_out;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
  } result_t;

  // broadcast command for the row of cells
  typedef struct packed {
    cell_mode_e               mode;
    logic [IDX_W-1:0]         pos_a;
    logic [IDX_W-1:0]         pos_b;
    logic [IDX_W-1:0]         last;
    logic signed [DATA_W-1:0] data_a;
    logic signed [DATA_W-1:0] data_b;
  } cell_cmd_t;

  typedef struct packed {
    logic                     clear;
    logic                     step;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         pos_a;
    logic [IDX_W-1:0]         pos_b;
    logic signed [DATA_W-1:0] key;
  } scan_ctl_t;

  typedef struct packed {
    logic                     found;
    logic [IDX_W-1:0]         fidx;
    logic signed [DATA_W-1:0] min_val;
    logic signed [DATA_W-1:0] max_val;
    logic signed [DATA_W-1:0] data_a;
    logic signed [DATA_W-1:0] data_b;
  } scan_res_t;

endpackage

FILE: rtl/core/bsle_cell.sv
// one list entry of the cell row
module bsle_cell (
  input  logic                              clk_i,
  input  bsle_pkg::cell_cmd_t               cmd_i,
  input  logic [bsle_pkg::IDX_W-1:0]        idx_i,
  input  logic signed [bsle_pkg::DATA_W-1:0] left_i,
  input  logic signed [bsle_pkg::DATA_W-1:0] right_i,
  input  logic signed [bsle_pkg::DATA_W-1:0] head_i,
  output logic signed [bsle_pkg::DATA_W-1:0] data_o
);
  import bsle_pkg::*;

  logic signed [DATA_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.mode)
      CM_HOLD: ;
      // rotate toward the head, head wraps to the tail
      CM_ROT: begin
        data_d = (idx_i == cmd_i.last) ? head_i : right_i;
      end
      CM_INS: begin
        if (idx_i == cmd_i.pos_a) begin
          data_d = cmd_i.data_a;
        end else if (idx_i > cmd_i.pos_a) begin
          data_d = left_i;
        end
      end
      CM_DEL: begin
        if (idx_i >= cmd_i.pos_a) begin
          data_d = right_i;
        end
      end
      CM_SWAP: begin
        if (idx_i == cmd_i.pos_a) begin
          data_d = cmd_i.data_a;
        end else if (idx_i == cmd_i.pos_b) begin
          data_d = cmd_i.data_b;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/core/bsle_scan.sv
// scan unit watching the head cell during a rotation pass
module bsle_scan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bsle_pkg::scan_ctl_t                ctl_i,
  input  logic signed [bsle_pkg::DATA_W-1:0] head_i,
  output bsle_pkg::scan_res_t                res_o
);
  import bsle_pkg::*;

  logic                     first_q, found_q;
  logic [IDX_W-1:0]         fidx_q;
  logic signed [DATA_W-1:0] min_q, max_q, a_q, b_q;
  logic                     hit, lower, higher;

  assign hit    = !found_q && (head_i == ctl_i.key);
  assign lower  = first_q || (head_i < min_q);
  assign higher = first_q || (head_i > max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      first_q <= 1'b1;
      found_q <= 1'b0;
    end else if (ctl_i.step) begin
      first_q <= 1'b0;
      if (hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      if (hit) fidx_q <= ctl_i.idx;
      if (lower) min_q <= head_i;
      if (higher) max_q <= head_i;
      if (ctl_i.idx == ctl_i.pos_a) a_q <= head_i;
      if (ctl_i.idx == ctl_i.pos_b) b_q <= head_i;
    end
  end

  assign res_o = '{found: found_q, fidx: fidx_q, min_val: min_q, max_val: max_q,
                   data_a: a_q, data_b: b_q};

endmodule

FILE: rtl/core/bounded_sequential_list_engine.sv
// top level of the bounded sequential list engine: control and the cell row
//
// Keeps an ordered list of up to CAPACITY signed 32-bit words in a row of
// cells, one word per cell, positions counted from 1. A word is taken at the
// rising edge where start is high and busy is low; its result shows on
// result_o for exactly one cycle with done_o high and cannot be held off, so
// the receiver must take it then. Clear, insert, the unused opcode and every
// operation rejected by its status check (full, bad position, empty, not
// found on an empty list) answer in the cycle after the accept, and a new
// word can be taken in the same cycle that result is shown. Read, delete,
// locate, swap and extremes make a pass: the row rotates one place per cycle
// so each entry passes the head cell, where the scan unit looks at it, and
// after a full turn the list is back in order and the S_APPLY state applies
// the delete shift or the swap writes and drives the result. busy is high
// for the whole pass. Reset clears the entry count and the control state
// but not the cell contents, which need no clearing since no operation
// looks at an entry beyond the count.
module bounded_sequential_list_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bsle_pkg::item_t   item_i,
  output logic              done_o,
  output bsle_pkg::result_t result_o
);
  import bsle_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]               state_d, state_q;
  logic [CNT_W-1:0]         count_d, count_q;
  logic [IDX_W-1:0]         step_d, step_q;
  logic                     done_d, done_q;
  result_t                  res_d, res_q;
  logic [2:0]               op_d, op_q;
  logic [IDX_W-1:0]         pos_a_d, pos_a_q, pos_b_d, pos_b_q;
  logic signed [DATA_W-1:0] key_d, key_q;

  // position checks against the current count
  logic [CMP_W-1:0] p_ext, q_ext, cnt_ext;
  logic             p_in_list, q_in_list, p_ins_ok, list_full, list_empty;
  logic [IDX_W-1:0] last_idx;
  logic             go_scan;

  cell_cmd_t                cmd;
  scan_ctl_t                sctl;
  scan_res_t                sres;
  logic signed [DATA_W-1:0] cell_data  [CAPACITY];
  logic signed [DATA_W-1:0] cell_left  [CAPACITY];
  logic signed [DATA_W-1:0] cell_right [CAPACITY];

  assign p_ext      = CMP_W'(item_i.position);
  assign q_ext      = CMP_W'(item_i.second_position);
  assign cnt_ext    = CMP_W'(count_q);
  assign p_in_list  = (p_ext != '0) && (p_ext <= cnt_ext);
  assign q_in_list  = (q_ext != '0) && (q_ext <= cnt_ext);
  assign p_ins_ok   = (p_ext != '0) && (p_ext <= cnt_ext + CMP_W'(1));
  assign list_full  = (count_q == CNT_W'(CAPACITY));
  assign list_empty = (count_q == '0);
  assign last_idx   = IDX_W'(cnt_ext - CMP_W'(1));

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    step_d  = step_q;
    done_d  = 1'b0;
    res_d   = res_q;
    op_d    = op_q;
    pos_a_d = pos_a_q;
    pos_b_d = pos_b_q;
    key_d   = key_q;
    go_scan = 1'b0;

    cmd  = '{mode: CM_HOLD, pos_a: pos_a_q, pos_b: pos_b_q, last: last_idx,
             data_a: '0, data_b: '0};
    sctl = '{clear: 1'b0, step: 1'b0, idx: step_q, pos_a: pos_a_q,
             pos_b: pos_b_q, key: key_q};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          // latch the word, clear the result and the scan unit
          op_d        = item_i.opcode;
          pos_a_d     = IDX_W'(p_ext - CMP_W'(1));
          pos_b_d     = IDX_W'(q_ext - CMP_W'(1));
          key_d       = item_i.value;
          res_d       = '0;
          step_d      = '0;
          sctl.clear  = 1'b1;
          case (item_i.opcode)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_INSERT: begin
              if (list_full) begin
                res_d.status = ST_FULL;
              end else if (!p_ins_ok) begin
                res_d.status = ST_BADPOS;
              end else begin
                // open a gap at the target and drop the new word in
                cmd.mode   = CM_INS;
                cmd.pos_a  = IDX_W'(p_ext - CMP_W'(1));
                cmd.data_a = item_i.value;
                count_d    = count_q + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (list_empty) begin
                res_d.status = ST_EMPTY;
              end else if (!p_in_list) begin
                res_d.status = ST_BADPOS;
              end else begin
                go_scan = 1'b1;
              end
            end
            OP_READ: begin
              if (!p_in_list) res_d.status = ST_BADPOS;
              else go_scan = 1'b1;
            end
            OP_LOCATE: begin
              if (list_empty) res_d.status = ST_NOTFOUND;
              else go_scan = 1'b1;
            end
            OP_SWAP: begin
              if (!p_in_list || !q_in_list || (p_ext == q_ext)) begin
                res_d.status = ST_BADPOS;
              end else begin
                go_scan = 1'b1;
              end
            end
            OP_EXTREMES: begin
              if (list_empty) res_d.status = ST_EMPTY;
              else go_scan = 1'b1;
            end
            default: ;
          endcase
          if (go_scan) begin
            state_d = S_SCAN;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // cell 0 holds entry step_q during this cycle
        cmd.mode  = CM_ROT;
        sctl.step = 1'b1;
        step_d    = step_q + IDX_W'(1);
        if (step_q == last_idx) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        // list is back in order, scan results are final
        done_d  = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          OP_DELETE: begin
            res_d.read_value = sres.data_a;
            cmd.mode         = CM_DEL;
            count_d          = count_q - CNT_W'(1);
          end
          OP_READ: begin
            res_d.read_value = sres.data_a;
          end
          OP_LOCATE: begin
            if (sres.found) begin
              res_d.found_position = POS_W'(CMP_W'(sres.fidx) + CMP_W'(1));
            end else begin
              res_d.status = ST_NOTFOUND;
            end
          end
          OP_SWAP: begin
            cmd.mode   = CM_SWAP;
            cmd.data_a = sres.data_b;
            cmd.data_b = sres.data_a;
          end
          OP_EXTREMES: begin
            res_d.min_value = sres.min_val;
            res_d.max_value = sres.max_val;
          end
          default: ;
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_d) begin
      res_d.list_length_out = POS_W'(count_d);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // latched word and result payload
  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    op_q    <= op_d;
    pos_a_q <= pos_a_d;
    pos_b_q <= pos_b_d;
    key_q   <= key_d;
  end

  // row of cells, cell 0 is the head
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cell_left[k] = '0;
    end else begin : g_mid_l
      assign cell_left[k] = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign cell_right[k] = '0;
    end else begin : g_mid_r
      assign cell_right[k] = cell_data[k+1];
    end

    bsle_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(k)),
      .left_i  (cell_left[k]),
      .right_i (cell_right[k]),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[k])
    );
  end

  bsle_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sctl),
    .head_i (cell_data[0]),
    .res_o  (sres)
  );

endmodule

FILE: rtl/core/bsle_checker.sv
// port-level checks for the list engine, bound to the top level
module bsle_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input bsle_pkg::item_t   item_i,
  input logic              done_o,
  input bsle_pkg::result_t result_o
);
  import bsle_pkg::*;

  // an accepted word either answers at once or starts a pass
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o || busy)
    else $error("accepted word neither answered nor started a pass");

  // a result never shows while a pass is still running
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // clear answers next cycle with an empty list
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.opcode == OP_CLEAR |=>
      done_o && result_o.list_length_out == '0 && result_o.status == ST_OK)
    else $error("clear did not empty the list");

  // full status only with the list at capacity
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ST_FULL |->
      result_o.list_length_out == POS_W'(CAPACITY))
    else $error("full status with list below capacity");

endmodule

bind bounded_sequential_list_engine bsle_checker u_bsle_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);
